### rtl/pip_pkg.sv
// Shared types and codes of the point-in-polygon tester.
package pip_pkg;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	// register select: paddr bit 2
	localparam logic IDX_INVERT = 1'b0;

	typedef struct packed {
		logic               func;
		logic               restart;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
	} req_t;

	typedef struct packed {
		logic inside_res;
		logic keep;
		logic vertex_overflow;
	} rsp_t;

	typedef struct packed {
		logic q_full;
		logic q_empty;
		logic back_busy;
	} hold_t;

endpackage

### rtl/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/pip_queue.sv
// Short queue of query words between front and back end.
module pip_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == NW'(DEPTH));
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### rtl/pip_front.sv
// Front end: takes request words, stores vertices, queues queries.
module pip_front #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 32
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            req_valid,
	output logic                                            req_stall,
	input  pip_pkg::req_t                                   req,
	input  pip_pkg::hold_t                                  hold,
	output logic                                            q_push,
	output logic [2*COORD_BITS+$clog2(MAX_VERTICES+1):0]    q_word,
	output logic                                            ram_we,
	output logic [$clog2(MAX_VERTICES)-1:0]                 ram_waddr,
	output logic [2*COORD_BITS-1:0]                         ram_wdata
);

	import pip_pkg::*;

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES);

	logic signed [COORD_BITS-1:0] cx;
	logic signed [COORD_BITS-1:0] cy;
	logic [CW-1:0]                count_q;
	logic                         ovf_q;
	logic [CW-1:0]                base;
	logic                         accept;
	logic                         is_append;
	logic                         room;

	assign cx = COORD_BITS'($signed(req.coord_x));
	assign cy = COORD_BITS'($signed(req.coord_y));

	// hold a query while the queue is full, and a restart append until the queue is empty and the back end is idle
	assign req_stall = (req.func == FUNC_QUERY) ? hold.q_full :
		(req.restart && (!hold.q_empty || hold.back_busy));

	assign accept    = req_valid && !req_stall;
	assign is_append = (req.func == FUNC_APPEND);
	assign base      = req.restart ? '0 : count_q;
	assign room      = (base < CW'(MAX_VERTICES));

	assign ram_we    = accept && is_append && room;
	assign ram_waddr = base[AW-1:0];
	assign ram_wdata = {cx, cy};

	assign q_push = accept && !is_append;
	assign q_word = {cx, cy, count_q, ovf_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept && is_append) begin
			if (room) begin
				count_q <= base + 1'b1;
				ovf_q   <= req.restart ? 1'b0 : ovf_q;
			end else begin
				ovf_q   <= 1'b1;
			end
		end
	end

endmodule

### rtl/pip_back.sv
// Back end: walks the stored edges of one query and forms its result word.
module pip_back #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 32
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            q_empty,
	input  logic [2*COORD_BITS+$clog2(MAX_VERTICES+1):0]    q_word,
	output logic                                            q_pop,
	output logic                                            busy,
	output logic                                            ram_re,
	output logic [$clog2(MAX_VERTICES)-1:0]                 ram_raddr,
	input  logic [2*COORD_BITS-1:0]                         ram_rdata,
	input  logic                                            invert,
	output logic                                            rsp_valid,
	input  logic                                            rsp_stall,
	output pip_pkg::rsp_t                                   rsp
);

	import pip_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int H  = (COORD_BITS + 1) / 2;
	localparam int HB = COORD_BITS - H;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic first;
		logic mid;
		logic close;
		logic last;
	} tok_t;

	function automatic logic [C-1:0] mag_of(input logic signed [C:0] d);
		logic [C:0] m;
		m = d[C] ? -d : d;
		return m[C-1:0];
	endfunction

	state_t                state_q;
	logic signed [C-1:0]   qx_q;
	logic signed [C-1:0]   qy_q;
	logic [CW-1:0]         n_q;
	logic                  ovf_q;
	logic [CW-1:0]         cnt_q;
	logic                  acc_q;
	logic [2*C-1:0]        first_q;
	logic [2*C-1:0]        prev_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	tok_t                  tok;
	tok_t                  tok_s1;
	logic                  at_end;
	logic                  start;

	logic signed [C-1:0]   xi, yi, xj, yj;
	logic                  spans, xok;

	logic                  edge_s2, last_s2;
	logic signed [C:0]     ay_s2, bx_s2, ax_s2, by_s2;

	logic                  edge_s3, last_s3, dypos_s3, lneg_s3, rneg_s3;
	logic [C-1:0]          lam_s3, lbm_s3, ram_s3, rbm_s3;

	logic                  edge_s4, last_s4, dypos_s4, lneg_s4, rneg_s4;
	logic [2*H-1:0]        l_ll_s4, r_ll_s4;
	logic [H+HB-1:0]       l_lh_s4, l_hl_s4, r_lh_s4, r_hl_s4;
	logic [2*HB-1:0]       l_hh_s4, r_hh_s4;

	logic                  edge_s5, last_s5, dypos_s5, lneg_s5, rneg_s5;
	logic [2*C-1:0]        l_mag_s5, r_mag_s5;

	logic                  edge_s6, last_s6, dypos_s6;
	logic signed [2*C:0]   l_s6, r_s6;

	logic                  less;
	logic                  parity_nx;

	assign busy      = (state_q != ST_IDLE);
	assign start     = (state_q == ST_IDLE) && !q_empty && (!rsp_valid_q || !rsp_stall);
	assign q_pop     = start;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// token issue: one vertex read per cycle, then the closing edge
	assign at_end    = (cnt_q == n_q);
	always_comb begin
		tok       = '0;
		if (state_q == ST_WALK) begin
			tok.first = !at_end && (cnt_q == '0);
			tok.mid   = !at_end && (cnt_q != '0);
			tok.close = at_end && (n_q != '0);
			tok.last  = at_end;
		end
	end
	assign ram_re    = tok.first || tok.mid;
	assign ram_raddr = cnt_q[AW-1:0];

	// edge formation against the stored previous and first vertex
	always_comb begin
		if (tok_s1.close) begin
			xi = first_q[2*C-1:C];
			yi = first_q[C-1:0];
		end else begin
			xi = ram_rdata[2*C-1:C];
			yi = ram_rdata[C-1:0];
		end
		xj = prev_q[2*C-1:C];
		yj = prev_q[C-1:0];
	end
	assign spans = ((yi < qy_q) && (yj >= qy_q)) || ((yj < qy_q) && (yi >= qy_q));
	assign xok   = (xi <= qx_q) || (xj <= qx_q);

	assign less      = dypos_s6 ? (l_s6 < r_s6) : (r_s6 < l_s6);
	assign parity_nx = acc_q ^ (edge_s6 && less);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			acc_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			tok_s1      <= '0;
			edge_s2     <= 1'b0;
			last_s2     <= 1'b0;
			edge_s3     <= 1'b0;
			last_s3     <= 1'b0;
			edge_s4     <= 1'b0;
			last_s4     <= 1'b0;
			edge_s5     <= 1'b0;
			last_s5     <= 1'b0;
			edge_s6     <= 1'b0;
			last_s6     <= 1'b0;
		end else begin
			tok_s1  <= tok;
			edge_s2 <= (tok_s1.mid || tok_s1.close) && spans && xok;
			last_s2 <= tok_s1.last;
			edge_s3 <= edge_s2;
			last_s3 <= last_s2;
			edge_s4 <= edge_s3;
			last_s4 <= last_s3;
			edge_s5 <= edge_s4;
			last_s5 <= last_s4;
			edge_s6 <= edge_s5;
			last_s6 <= last_s5;

			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						acc_q   <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (at_end) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (last_s6) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (state_q != ST_IDLE) begin
				acc_q <= parity_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qx_q  <= q_word[2*C+CW:C+CW+1];
			qy_q  <= q_word[C+CW:CW+1];
			n_q   <= q_word[CW:1];
			ovf_q <= q_word[0];
		end
		if (tok_s1.first) begin
			first_q <= ram_rdata;
			prev_q  <= ram_rdata;
		end else if (tok_s1.mid) begin
			prev_q  <= ram_rdata;
		end
		if (last_s6 && state_q == ST_DRAIN) begin
			rsp_q.inside_res      <= parity_nx;
			rsp_q.keep            <= parity_nx ^ invert;
			rsp_q.vertex_overflow <= ovf_q;
		end

		// differences
		ay_s2 <= (C+1)'(qy_q) - (C+1)'(yi);
		bx_s2 <= (C+1)'(xj) - (C+1)'(xi);
		ax_s2 <= (C+1)'(qx_q) - (C+1)'(xi);
		by_s2 <= (C+1)'(yj) - (C+1)'(yi);

		// magnitudes and product signs
		lam_s3   <= mag_of(ay_s2);
		lbm_s3   <= mag_of(bx_s2);
		ram_s3   <= mag_of(ax_s2);
		rbm_s3   <= mag_of(by_s2);
		lneg_s3  <= ay_s2[C] ^ bx_s2[C];
		rneg_s3  <= ax_s2[C] ^ by_s2[C];
		dypos_s3 <= !by_s2[C];

		// partial products
		l_ll_s4  <= (2*H)'(lam_s3[H-1:0]) * (2*H)'(lbm_s3[H-1:0]);
		l_lh_s4  <= (H+HB)'(lam_s3[H-1:0]) * (H+HB)'(lbm_s3[C-1:H]);
		l_hl_s4  <= (H+HB)'(lam_s3[C-1:H]) * (H+HB)'(lbm_s3[H-1:0]);
		l_hh_s4  <= (2*HB)'(lam_s3[C-1:H]) * (2*HB)'(lbm_s3[C-1:H]);
		r_ll_s4  <= (2*H)'(ram_s3[H-1:0]) * (2*H)'(rbm_s3[H-1:0]);
		r_lh_s4  <= (H+HB)'(ram_s3[H-1:0]) * (H+HB)'(rbm_s3[C-1:H]);
		r_hl_s4  <= (H+HB)'(ram_s3[C-1:H]) * (H+HB)'(rbm_s3[H-1:0]);
		r_hh_s4  <= (2*HB)'(ram_s3[C-1:H]) * (2*HB)'(rbm_s3[C-1:H]);
		lneg_s4  <= lneg_s3;
		rneg_s4  <= rneg_s3;
		dypos_s4 <= dypos_s3;

		// full magnitudes
		l_mag_s5 <= {l_hh_s4, l_ll_s4} + ((2*C)'(l_lh_s4) << H) + ((2*C)'(l_hl_s4) << H);
		r_mag_s5 <= {r_hh_s4, r_ll_s4} + ((2*C)'(r_lh_s4) << H) + ((2*C)'(r_hl_s4) << H);
		lneg_s5  <= lneg_s4;
		rneg_s5  <= rneg_s4;
		dypos_s5 <= dypos_s4;

		// signed products
		l_s6     <= lneg_s5 ? -$signed({1'b0, l_mag_s5}) : $signed({1'b0, l_mag_s5});
		r_s6     <= rneg_s5 ? -$signed({1'b0, r_mag_s5}) : $signed({1'b0, r_mag_s5});
		dypos_s6 <= dypos_s5;
	end

endmodule

### rtl/point_in_polygon_test.sv
// Top level of the even-odd point-in-polygon tester.
//
//  channel | handshake                | word  | direction
//  req     | req_valid / req_stall    | req_t | in: vertex append or query
//  rsp     | rsp_valid / rsp_stall    | rsp_t | out: one word per query
//  cfg     | psel/penable/pwrite      | 32 b  | in: invert_select at 0x0
//
// A query's walk in the back end is paced by its single vertex-table read port
// (one vertex a cycle) and a six-stage cross-product pipeline.
// A restart append waits until queued and running queries are finished.
// Reset clears vertex count, overflow flag, queue and invert_select; the vertex
// table itself is not cleared. rsp_stall holds the result register and, once a
// result waits, delays the next query while non-restart appends still go through.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pip_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pip_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	import pip_pkg::*;

	localparam int CW     = $clog2(MAX_VERTICES + 1);
	localparam int AW     = $clog2(MAX_VERTICES);
	localparam int QW     = 2 * COORD_BITS + CW + 1;
	localparam int QDEPTH = 4;

	hold_t                  hold;
	logic                   q_push;
	logic                   q_pop;
	logic [QW-1:0]          q_wdata;
	logic [QW-1:0]          q_rdata;
	logic                   q_empty;
	logic                   q_full;
	logic                   back_busy;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [2*COORD_BITS-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [2*COORD_BITS-1:0] ram_rdata;
	logic                   invert_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == IDX_INVERT) ? {31'b0, invert_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == IDX_INVERT) begin
			invert_q <= pwdata[0];
		end
	end

	assign hold.q_full    = q_full;
	assign hold.q_empty   = q_empty;
	assign hold.back_busy = back_busy;

	pip_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.hold     (hold),
		.q_push   (q_push),
		.q_word   (q_wdata),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	pip_queue #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty),
		.full  (q_full)
	);

	pip_ram #(
		.WIDTH(2 * COORD_BITS),
		.DEPTH(MAX_VERTICES)
	) u_vtx_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pip_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_word   (q_rdata),
		.q_pop    (q_pop),
		.busy     (back_busy),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.invert   (invert_q),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

### rtl/pip_checker.sv
// Port checker for the point-in-polygon tester and its bind.
module pip_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input pip_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input pip_pkg::rsp_t rsp,
	input logic          psel,
	input logic          pwrite,
	input logic [2:0]    paddr,
	input logic [31:0]   prdata
);

	import pip_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("rsp word dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("rsp word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && psel && !pwrite && paddr[2] == IDX_INVERT
		|-> rsp.keep == (rsp.inside_res ^ prdata[0]))
		else $error("keep does not follow invert_select");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.func == FUNC_QUERY
		|=> !(req_valid && !req_stall && req.func == FUNC_APPEND && req.restart))
		else $error("restart taken while a query is pending");

endmodule

bind point_in_polygon_test pip_checker u_chk (.*);

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of point_in_polygon_test: random vertex and query words, APB setup.
module tb;
	import pip_pkg::*;

	localparam int     MAX_VERTICES = 64;
	localparam int     DRAIN_CYCLES = MAX_VERTICES + 40;
	localparam int     HANG_LIMIT   = 5000;
	localparam int     LONG_HOLD    = 600;
	localparam int     MAX_REPORTS  = 10;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [69:0] prod_t;
	typedef enum int {STYLE_GRID, STYLE_MID, STYLE_FULL, STYLE_EDGE} style_t;

	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam coord_t C_MAX = 32'sh7FFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	point_in_polygon_test #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (32)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// polygon as the block should hold it
	coord_t vtx_x [MAX_VERTICES];
	coord_t vtx_y [MAX_VERTICES];
	int     vtx_count = 0;
	logic   vtx_overflow = 1'b0;
	logic   invert_now = 1'b0;

	req_t   word_q [$];
	rsp_t   expected_rsp_q [$];
	coord_t shape_x [$];
	coord_t shape_y [$];

	int   words_queued = 0;
	int   words_taken = 0;
	int   queries_sent = 0;
	int   results_seen = 0;
	int   inside_seen = 0;
	int   overflow_seen = 0;
	int   errors = 0;
	int   send_gap = 0;
	int   send_calm = 0;
	int   recv_gap = 0;
	int   recv_calm = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	logic idle_on = 1'b1;
	logic long_hold_arm = 1'b0;
	logic long_hold_done = 1'b0;

	function automatic logic crossing_parity(input coord_t qx, input coord_t qy);
		prod_t xi, yi, xj, yj, px, py, dy, lhs, rhs;
		logic  parity, spans, flip;
		int    i, j;
		parity = 1'b0;
		if (vtx_count == 0)
			return 1'b0;
		px = qx;
		py = qy;
		j = vtx_count - 1;
		for (i = 0; i < vtx_count; i++) begin
			xi = vtx_x[i];
			yi = vtx_y[i];
			xj = vtx_x[j];
			yj = vtx_y[j];
			spans = (yi < py && yj >= py) || (yj < py && yi >= py);
			if (spans && (xi <= px || xj <= px)) begin
				dy = yj - yi;
				lhs = (py - yi) * (xj - xi);
				rhs = (px - xi) * dy;
				flip = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
				if (flip)
					parity = ~parity;
			end
			j = i;
		end
		return parity;
	endfunction

	task automatic predict_word(input req_t w);
		rsp_t r;
		logic hit;
		if (w.func == FUNC_APPEND) begin
			if (w.restart) begin
				vtx_count = 0;
				vtx_overflow = 1'b0;
			end
			if (vtx_count < MAX_VERTICES) begin
				vtx_x[vtx_count] = w.coord_x;
				vtx_y[vtx_count] = w.coord_y;
				vtx_count++;
			end else begin
				vtx_overflow = 1'b1;
			end
		end else begin
			hit = crossing_parity(w.coord_x, w.coord_y);
			r.inside_res = hit;
			r.keep = hit ^ invert_now;
			r.vertex_overflow = vtx_overflow;
			expected_rsp_q = {expected_rsp_q, r};
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		req_t next_word;
		logic next_valid;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			next_word = req;
			next_valid = req_valid;
			if (req_valid && !req_stall) begin
				predict_word(req);
				words_taken++;
				next_valid = 1'b0;
			end
			if (!(req_valid && req_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (idle_on && send_calm == 0 && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 15);
				end else if (word_q.size() != 0) begin
					next_word = word_q.pop_front();
					next_valid = 1'b1;
				end
			end
			if (send_calm > 0)
				send_calm--;
			else if ($urandom_range(0, 63) == 0)
				send_calm = $urandom_range(20, 80);
			req_valid <= next_valid;
			req <= next_word;
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (long_hold_arm && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			rsp_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			rsp_stall <= 1'b1;
		end else if (idle_on && recv_calm == 0 && $urandom_range(0, 4) == 0) begin
			recv_gap = $urandom_range(0, 15);
			rsp_stall <= 1'b1;
		end else begin
			if (recv_calm > 0)
				recv_calm--;
			else if ($urandom_range(0, 63) == 0)
				recv_calm = $urandom_range(20, 80);
			rsp_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (rsp.inside_res === 1'b1)
				inside_seen++;
			if (rsp.vertex_overflow === 1'b1)
				overflow_seen++;
			if (expected_rsp_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result word: inside=%b keep=%b ovf=%b",
						rsp.inside_res, rsp.keep, rsp.vertex_overflow);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.inside_res !== want.inside_res || rsp.keep !== want.keep ||
				    rsp.vertex_overflow !== want.vertex_overflow) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("result %0d (inside keep ovf): expected %b%b%b, got %b%b%b",
							results_seen, want.inside_res, want.keep,
							want.vertex_overflow, rsp.inside_res, rsp.keep,
							rsp.vertex_overflow);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles, %0d results pending",
				HANG_LIMIT, expected_rsp_q.size());
			$display("** point_in_polygon_test: FAILED **");
			$finish;
		end
	end

	function automatic coord_t fx(input int v);
		return coord_t'(v * 65536);
	endfunction

	function automatic coord_t pick_coord(input style_t style);
		int v;
		case (style)
			STYLE_GRID: begin
				v = (int'($urandom_range(0, 32)) - 16) * 65536;
				if ($urandom_range(0, 3) == 0)
					v = v + int'($urandom_range(0, 65535));
				return coord_t'(v);
			end
			STYLE_MID:  return coord_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
			STYLE_FULL: return coord_t'($urandom);
			default: begin
				case ($urandom_range(0, 6))
					0: return C_MIN;
					1: return C_MAX;
					2: return 32'sd0;
					3: return -32'sd1;
					4: return 32'sd1;
					5: return C_MIN + 32'sd1;
					default: return C_MAX - 32'sd1;
				endcase
			end
		endcase
	endfunction

	function automatic style_t pick_style();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return STYLE_GRID;
		if (r < 15)
			return STYLE_MID;
		if (r < 18)
			return STYLE_FULL;
		return STYLE_EDGE;
	endfunction

	task automatic push_word(input logic func, input logic restart, input coord_t x,
	                         input coord_t y);
		req_t w;
		w.func = func;
		w.restart = restart;
		w.coord_x = x;
		w.coord_y = y;
		word_q = {word_q, w};
		words_queued++;
		if (func == FUNC_QUERY)
			queries_sent++;
	endtask

	task automatic add_vertex(input logic restart, input coord_t x, input coord_t y);
		if (restart) begin
			shape_x.delete();
			shape_y.delete();
		end
		shape_x = {shape_x, x};
		shape_y = {shape_y, y};
		push_word(FUNC_APPEND, restart, x, y);
	endtask

	function automatic coord_t pick_query(input style_t style, input logic axis_y);
		logic signed [32:0] s;
		int a, b, r;
		if (shape_x.size() == 0)
			return pick_coord(style);
		a = $urandom_range(0, shape_x.size() - 1);
		b = $urandom_range(0, shape_x.size() - 1);
		r = $urandom_range(0, 19);
		if (r < 8)
			return axis_y ? shape_y[a] : shape_x[a];
		if (r < 11) begin
			s = axis_y ? (shape_y[a] + shape_y[b]) : (shape_x[a] + shape_x[b]);
			return s[32:1];
		end
		if (r < 17)
			return pick_coord(style);
		return coord_t'($urandom);
	endfunction

	task automatic random_rounds(input int budget, input int first_size);
		int     stop_at, n, k, i;
		style_t style;
		logic   first;
		stop_at = words_queued + budget;
		first = 1'b1;
		while (words_queued < stop_at) begin
			style = pick_style();
			if (!first && $urandom_range(0, 9) == 0) begin
				// extend the current polygon without restart
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					add_vertex(1'b0, pick_coord(style), pick_coord(style));
			end else begin
				if (first && first_size > 0)
					n = first_size;
				else begin
					k = $urandom_range(0, 19);
					if (k == 0)
						n = $urandom_range(60, 70);
					else if (k < 3)
						n = $urandom_range(1, 2);
					else
						n = $urandom_range(3, 10);
				end
				for (i = 0; i < n; i++)
					add_vertex(i == 0, pick_coord(style), pick_coord(style));
			end
			first = 1'b0;
			k = $urandom_range(1, 6);
			for (i = 0; i < k; i++)
				push_word(FUNC_QUERY, $urandom_range(0, 9) == 0,
					pick_query(style, 1'b0), pick_query(style, 1'b1));
		end
	endtask

	task automatic write_invert(input logic value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {IDX_INVERT, 2'b00};
		pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		invert_now = value;
	endtask

	task automatic settle();
		while (words_taken != words_queued || expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_invert(1'b0);

		// empty polygon, one vertex, two vertices
		push_word(FUNC_QUERY, 1'b0, 32'sd0, 32'sd0);
		add_vertex(1'b1, 32'sd0, 32'sd0);
		push_word(FUNC_QUERY, 1'b0, 32'sd0, 32'sd0);
		add_vertex(1'b0, fx(10), fx(4));
		push_word(FUNC_QUERY, 1'b0, fx(6), fx(2));
		// square of side fx(10): interior, exterior, every edge and a corner
		add_vertex(1'b1, fx(0), fx(0));
		add_vertex(1'b0, fx(10), fx(0));
		add_vertex(1'b0, fx(10), fx(10));
		add_vertex(1'b0, fx(0), fx(10));
		push_word(FUNC_QUERY, 1'b0, fx(5), fx(5));
		push_word(FUNC_QUERY, 1'b0, fx(15), fx(5));
		push_word(FUNC_QUERY, 1'b0, fx(0), fx(5));
		push_word(FUNC_QUERY, 1'b0, fx(10), fx(5));
		push_word(FUNC_QUERY, 1'b0, fx(5), fx(0));
		push_word(FUNC_QUERY, 1'b0, fx(5), fx(10));
		push_word(FUNC_QUERY, 1'b0, fx(0), fx(0));
		push_word(FUNC_QUERY, 1'b1, fx(5), fx(5));
		// full-range square
		add_vertex(1'b1, C_MIN, C_MIN);
		add_vertex(1'b0, C_MAX, C_MIN);
		add_vertex(1'b0, C_MAX, C_MAX);
		add_vertex(1'b0, C_MIN, C_MAX);
		push_word(FUNC_QUERY, 1'b0, 32'sd0, 32'sd0);
		push_word(FUNC_QUERY, 1'b0, C_MAX, C_MAX);
		push_word(FUNC_QUERY, 1'b0, C_MIN, C_MIN);
		push_word(FUNC_QUERY, 1'b0, C_MIN, -32'sd1);
		settle();

		write_invert(1'b1);
		random_rounds(190, MAX_VERTICES + 2);
		settle();

		write_invert(1'b0);
		long_hold_arm <= 1'b1;
		random_rounds(190, 0);
		settle();

		idle_on <= 1'b0;
		write_invert(1'b1);
		random_rounds(50, 0);
		settle();

		errors += expected_rsp_q.size();
		$display("covered %0d words, %0d queries checked, %0d inside, %0d overflowed",
			words_taken, results_seen, inside_seen, overflow_seen);
		$display("both invert settings, idle bursts on both sides, one %0d-cycle result hold",
			LONG_HOLD);
		if (errors == 0) begin
			$display("** point_in_polygon_test: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** point_in_polygon_test: FAILED **");
		end
		$finish;
	end

endmodule
